// ----- rtl/pli_pkg.sv -----
// ----------------------------------------------------------------------------
// pli_pkg: shared types, constants and functions
// Widths of the fixed-point datapath, the arctangent table and the
// quadrant fold used by the line intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

   localparam int FRAC_BITS_DEF    = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   // command codes carried in req_tuser
   localparam logic CMD_GIVEN   = 1'b0;
   localparam logic CMD_HEADING = 1'b1;

   // CORDIC x, y, z width (Q2.30 and 2^-32 turn angles with headroom)
   localparam int CW = 34;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam int D_W    = 64;   // |det|
   localparam int NUM_W  = 66;   // |numerator|
   localparam int REM_W  = 99;   // divider partial remainder
   localparam int QUO_W  = 35;   // divider quotient, bits 34..0

   localparam logic [31:0] DET_THRESHOLD_RESET = 32'd4295;

   function automatic logic [31:0] atan_turn(input int idx);
      logic [31:0] a;
      case (idx)
         0:       a = 32'd536870912;
         1:       a = 32'd316933406;
         2:       a = 32'd167458907;
         3:       a = 32'd85004756;
         4:       a = 32'd42667331;
         5:       a = 32'd21354465;
         6:       a = 32'd10679838;
         7:       a = 32'd5340245;
         8:       a = 32'd2670163;
         9:       a = 32'd1335087;
         10:      a = 32'd667544;
         11:      a = 32'd333772;
         12:      a = 32'd166886;
         13:      a = 32'd83443;
         14:      a = 32'd41722;
         15:      a = 32'd20861;
         16:      a = 32'd10430;
         17:      a = 32'd5215;
         18:      a = 32'd2608;
         19:      a = 32'd1304;
         20:      a = 32'd652;
         21:      a = 32'd326;
         22:      a = 32'd163;
         23:      a = 32'd81;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

   // rotate (cos, sin) by q+1 quarter turns into the normal {nx, ny}
   function automatic logic [63:0] quad_rot(input logic [1:0] q,
                                           input logic signed [31:0] c,
                                           input logic signed [31:0] s);
      logic [63:0] r;
      case (q)
         2'd0:    r = {-s, c};
         2'd1:    r = {-c, -s};
         2'd2:    r = {s, -c};
         default: r = {c, s};
      endcase
      return r;
   endfunction

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] p1x;
      logic signed [31:0] p1y;
      logic signed [31:0] p2x;
      logic signed [31:0] p2y;
      logic signed [31:0] n1x;
      logic signed [31:0] n1y;
      logic signed [31:0] n2x;
      logic signed [31:0] n2y;
      logic [1:0]         q1;
      logic [1:0]         q2;
   } item_type;

   typedef struct packed {
      logic               found;
      logic               neg_x;
      logic               neg_y;
      logic signed [31:0] p1x;
      logic signed [31:0] p1y;
      logic [D_W-1:0]     d;
   } div_type;

endpackage

`default_nettype wire

// ----- rtl/perpendicular_line_intersection.sv -----
// ----------------------------------------------------------------------------
// perpendicular_line_intersection: intersection point of two 2D lines
// Pipelined solver: CORDIC normals, determinant, divider chain, saturation.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per pair of lines: tuser is the command (1 derives
//   the direction normals from the headings by CORDIC, 0 takes them as given).
//   rsp_* returns one word per request, in order: center point in tdata,
//   found and saturated flags in tuser.
//   csr_wr_en/csr_wr_data load det_threshold; write it only while idle.
// Pipeline: an entry register, the row of CORDIC cells, stages A to F, the
//   35-cell restoring divider and the output register.
// Throughput: one word per cycle unless stalled; the stage registers advance together.
// Reset: all stage valid bits clear, det_threshold returns to 4295.
// Stall: while rsp_tvalid is high and rsp_tready low the whole pipeline holds
//   and req_tready drops; no word is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module perpendicular_line_intersection #(
   parameter int FRAC_BITS    = pli_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = pli_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [31:0]  csr_wr_data,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata: p1_x, p1_y, p1_heading, n1_x, n1_y, p2_x, p2_y, p2_heading, n2_x, n2_y
   input  wire logic [287:0] req_tdata,
   // tuser: command
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata: center_x, center_y
   output logic [63:0]       rsp_tdata,
   // tuser: found, saturated
   output logic [1:0]        rsp_tuser
);
   import pli_pkg::*;

   localparam int SH     = 30 - FRAC_BITS;
   localparam int THR_UP = (2*FRAC_BITS >= 32) ? 2*FRAC_BITS - 32 : 0;
   localparam int THR_DN = (2*FRAC_BITS < 32) ? 32 - 2*FRAC_BITS : 0;
   localparam int NDIV   = QUO_W;

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic [31:0] thr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= DET_THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // ---------------- entry: split headings into quadrant and remainder
   logic [15:0]          h1, h2, hs1, hs2, r1, r2;
   logic [1:0]           q1, q2;
   logic signed [CW-1:0] z1_in, z2_in;
   item_type             it_in;

   always_comb begin
      h1  = req_tdata[79:64];
      h2  = req_tdata[223:208];
      hs1 = h1 + 16'h2000;
      hs2 = h2 + 16'h2000;
      q1  = hs1[15:14];
      q2  = hs2[15:14];
      r1  = h1 - {q1, 14'd0};
      r2  = h2 - {q2, 14'd0};
      z1_in = $signed({{(CW-32){r1[15]}}, r1, 16'd0});
      z2_in = $signed({{(CW-32){r2[15]}}, r2, 16'd0});
      it_in.cmd = req_tuser;
      it_in.p1x = req_tdata[31:0];
      it_in.p1y = req_tdata[63:32];
      it_in.n1x = req_tdata[111:80];
      it_in.n1y = req_tdata[143:112];
      it_in.p2x = req_tdata[175:144];
      it_in.p2y = req_tdata[207:176];
      it_in.n2x = req_tdata[255:224];
      it_in.n2y = req_tdata[287:256];
      it_in.q1  = q1;
      it_in.q2  = q2;
   end

   item_type             pay_ff [0:CORDIC_STEPS];
   logic                 vc_ff  [0:CORDIC_STEPS];
   logic signed [CW-1:0] z1_ff, z2_ff;
   logic signed [CW-1:0] cx1 [0:CORDIC_STEPS];
   logic signed [CW-1:0] cy1 [0:CORDIC_STEPS];
   logic signed [CW-1:0] cz1 [0:CORDIC_STEPS];
   logic signed [CW-1:0] cx2 [0:CORDIC_STEPS];
   logic signed [CW-1:0] cy2 [0:CORDIC_STEPS];
   logic signed [CW-1:0] cz2 [0:CORDIC_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         pay_ff[0] <= it_in;
         z1_ff     <= z1_in;
         z2_ff     <= z2_in;
         for (int k = 1; k <= CORDIC_STEPS; k++) begin
            pay_ff[k] <= pay_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= CORDIC_STEPS; k++) begin
            vc_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vc_ff[0] <= req_tvalid;
         for (int k = 1; k <= CORDIC_STEPS; k++) begin
            vc_ff[k] <= vc_ff[k-1];
         end
      end
   end

   assign cx1[0] = CORDIC_GAIN;
   assign cy1[0] = '0;
   assign cz1[0] = z1_ff;
   assign cx2[0] = CORDIC_GAIN;
   assign cy2[0] = '0;
   assign cz2[0] = z2_ff;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      pli_cordic_cell #(.STEP(g)) u_lane1 (
         .clock (clock), .en (en),
         .src_x (cx1[g]),   .src_y (cy1[g]),   .src_z (cz1[g]),
         .dst_x (cx1[g+1]), .dst_y (cy1[g+1]), .dst_z (cz1[g+1])
      );
      pli_cordic_cell #(.STEP(g)) u_lane2 (
         .clock (clock), .en (en),
         .src_x (cx2[g]),   .src_y (cy2[g]),   .src_z (cz2[g]),
         .dst_x (cx2[g+1]), .dst_y (cy2[g+1]), .dst_z (cz2[g+1])
      );
   end

   // ---------------- stage A: round, fold quadrant, pick normals
   localparam logic signed [CW-1:0] RND = CW'(1) <<< (SH - 1);
   logic signed [CW-1:0] c1w, s1w, c2w, s2w;
   logic [63:0]          nrm1, nrm2;
   item_type             pe;
   logic signed [31:0]   a_n1x_in, a_n1y_in, a_n2x_in, a_n2y_in;

   always_comb begin
      pe   = pay_ff[CORDIC_STEPS];
      c1w  = (cx1[CORDIC_STEPS] + RND) >>> SH;
      s1w  = (cy1[CORDIC_STEPS] + RND) >>> SH;
      c2w  = (cx2[CORDIC_STEPS] + RND) >>> SH;
      s2w  = (cy2[CORDIC_STEPS] + RND) >>> SH;
      nrm1 = quad_rot(pe.q1, c1w[31:0], s1w[31:0]);
      nrm2 = quad_rot(pe.q2, c2w[31:0], s2w[31:0]);
      if (pe.cmd == CMD_HEADING) begin
         a_n1x_in = nrm1[63:32];
         a_n1y_in = nrm1[31:0];
         a_n2x_in = nrm2[63:32];
         a_n2y_in = nrm2[31:0];
      end else begin
         a_n1x_in = pe.n1x;
         a_n1y_in = pe.n1y;
         a_n2x_in = pe.n2x;
         a_n2y_in = pe.n2y;
      end
   end

   logic               a_v_ff;
   logic signed [31:0] a_n1x_ff, a_n1y_ff, a_n2x_ff, a_n2y_ff, a_p1x_ff, a_p1y_ff;
   logic signed [32:0] a_dx_ff, a_dy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a_n1x_ff <= a_n1x_in;
         a_n1y_ff <= a_n1y_in;
         a_n2x_ff <= a_n2x_in;
         a_n2y_ff <= a_n2y_in;
         a_p1x_ff <= pe.p1x;
         a_p1y_ff <= pe.p1y;
         a_dx_ff  <= $signed({pe.p1x[31], pe.p1x}) - $signed({pe.p2x[31], pe.p2x});
         a_dy_ff  <= $signed({pe.p1y[31], pe.p1y}) - $signed({pe.p2y[31], pe.p2y});
      end
   end

   // ---------------- stage B: products
   logic               b_v_ff;
   logic signed [63:0] b_pd1_ff, b_pd2_ff;
   logic signed [64:0] b_pa_ff, b_pb_ff;
   logic signed [31:0] b_n1x_ff, b_n1y_ff, b_p1x_ff, b_p1y_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         b_pd1_ff <= 64'(a_n1y_ff) * 64'(a_n2x_ff);
         b_pd2_ff <= 64'(a_n1x_ff) * 64'(a_n2y_ff);
         b_pa_ff  <= 65'(a_dx_ff) * 65'(a_n2y_ff);
         b_pb_ff  <= 65'(a_dy_ff) * 65'(a_n2x_ff);
         b_n1x_ff <= a_n1x_ff;
         b_n1y_ff <= a_n1y_ff;
         b_p1x_ff <= a_p1x_ff;
         b_p1y_ff <= a_p1y_ff;
      end
   end

   // ---------------- stage C: determinant and numerator
   logic               c_v_ff;
   logic signed [64:0] c_det_ff;
   logic signed [66:0] c_num_ff;
   logic signed [31:0] c_n1x_ff, c_n1y_ff, c_p1x_ff, c_p1y_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c_det_ff <= 65'(b_pd1_ff) - 65'(b_pd2_ff);
         c_num_ff <= 67'(b_pa_ff) - 67'(b_pb_ff);
         c_n1x_ff <= b_n1x_ff;
         c_n1y_ff <= b_n1y_ff;
         c_p1x_ff <= b_p1x_ff;
         c_p1y_ff <= b_p1y_ff;
      end
   end

   // ---------------- stage D: magnitudes and threshold test
   logic [64:0]      thr_w;
   logic [64:0]      det_mag_w;
   logic [66:0]      num_mag_w;
   logic             det_neg, num_neg;

   always_comb begin
      thr_w     = ((65'(thr_ff) + ((65'(1) << THR_DN) - 65'(1))) >> THR_DN) << THR_UP;
      det_neg   = c_det_ff[64];
      num_neg   = c_num_ff[66];
      det_mag_w = det_neg ? 65'(-c_det_ff) : 65'(c_det_ff);
      num_mag_w = num_neg ? 67'(-c_num_ff) : 67'(c_num_ff);
   end

   logic               d_v_ff, d_found_ff, d_negx_ff, d_negy_ff;
   logic [D_W-1:0]     d_det_ff;
   logic [NUM_W-1:0]   d_num_ff;
   logic [31:0]        d_mx_ff, d_my_ff;
   logic signed [31:0] d_p1x_ff, d_p1y_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         d_found_ff <= (det_mag_w != '0) && (det_mag_w >= thr_w);
         d_det_ff   <= det_mag_w[D_W-1:0];
         d_num_ff   <= num_mag_w[NUM_W-1:0];
         d_mx_ff    <= c_n1x_ff[31] ? 32'(-c_n1x_ff) : 32'(c_n1x_ff);
         d_my_ff    <= c_n1y_ff[31] ? 32'(-c_n1y_ff) : 32'(c_n1y_ff);
         d_negx_ff  <= num_neg ^ c_n1x_ff[31] ^ det_neg;
         d_negy_ff  <= num_neg ^ c_n1y_ff[31] ^ det_neg;
         d_p1x_ff   <= c_p1x_ff;
         d_p1y_ff   <= c_p1y_ff;
      end
   end

   // ---------------- stage E: partial products of numerator times direction
   logic        e_v_ff;
   logic [64:0] e_xl_ff, e_xh_ff, e_yl_ff, e_yh_ff;
   div_type     e_pay_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         e_xl_ff <= 65'(d_num_ff[32:0]) * 65'(d_mx_ff);
         e_xh_ff <= 65'(d_num_ff[65:33]) * 65'(d_mx_ff);
         e_yl_ff <= 65'(d_num_ff[32:0]) * 65'(d_my_ff);
         e_yh_ff <= 65'(d_num_ff[65:33]) * 65'(d_my_ff);
         e_pay_ff.found <= d_found_ff;
         e_pay_ff.neg_x <= d_negx_ff;
         e_pay_ff.neg_y <= d_negy_ff;
         e_pay_ff.p1x   <= d_p1x_ff;
         e_pay_ff.p1y   <= d_p1y_ff;
         e_pay_ff.d     <= d_det_ff;
      end
   end

   // ---------------- stage F: dividends, then the divider row
   logic [REM_W-1:0] rx [0:NDIV];
   logic [REM_W-1:0] ry [0:NDIV];
   logic [QUO_W-1:0] qx [0:NDIV];
   logic [QUO_W-1:0] qy [0:NDIV];
   div_type          dp_ff [0:NDIV];
   logic             vd_ff [0:NDIV];
   logic [REM_W-1:0] f_nx_ff, f_ny_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         f_nx_ff  <= REM_W'(e_xl_ff) + (REM_W'(e_xh_ff) << 33);
         f_ny_ff  <= REM_W'(e_yl_ff) + (REM_W'(e_yh_ff) << 33);
         dp_ff[0] <= e_pay_ff;
         for (int k = 1; k <= NDIV; k++) begin
            dp_ff[k] <= dp_ff[k-1];
         end
      end
   end

   assign rx[0] = f_nx_ff;
   assign ry[0] = f_ny_ff;
   assign qx[0] = '0;
   assign qy[0] = '0;

   for (genvar g = 0; g < NDIV; g++) begin : g_div
      pli_div_cell #(.SHIFT(NDIV - 1 - g)) u_x (
         .clock (clock), .en (en), .d (dp_ff[g].d),
         .src_rem (rx[g]), .src_quo (qx[g]),
         .dst_rem (rx[g+1]), .dst_quo (qx[g+1])
      );
      pli_div_cell #(.SHIFT(NDIV - 1 - g)) u_y (
         .clock (clock), .en (en), .d (dp_ff[g].d),
         .src_rem (ry[g]), .src_quo (qy[g]),
         .dst_rem (ry[g+1]), .dst_quo (qy[g+1])
      );
   end

   // ---------------- output stage: clamp quotient, add, saturate
   localparam logic [QUO_W-1:0] QCAP = QUO_W'(1) << 33;
   div_type            dl;
   logic [QUO_W-1:0]   qcx, qcy;
   logic signed [36:0] sx, sy;
   logic               satx, saty;
   logic signed [31:0] ox, oy;

   always_comb begin
      dl  = dp_ff[NDIV];
      qcx = (qx[NDIV] > QCAP) ? QCAP : qx[NDIV];
      qcy = (qy[NDIV] > QCAP) ? QCAP : qy[NDIV];
      sx  = 37'(dl.p1x) + (dl.neg_x ? -$signed({2'b00, qcx}) : $signed({2'b00, qcx}));
      sy  = 37'(dl.p1y) + (dl.neg_y ? -$signed({2'b00, qcy}) : $signed({2'b00, qcy}));
      satx = (sx > 37'sd2147483647) || (sx < -37'sd2147483648);
      saty = (sy > 37'sd2147483647) || (sy < -37'sd2147483648);
      if (sx > 37'sd2147483647) begin
         ox = 32'sh7FFFFFFF;
      end else if (sx < -37'sd2147483648) begin
         ox = 32'sh80000000;
      end else begin
         ox = sx[31:0];
      end
      if (sy > 37'sd2147483647) begin
         oy = 32'sh7FFFFFFF;
      end else if (sy < -37'sd2147483648) begin
         oy = 32'sh80000000;
      end else begin
         oy = sy[31:0];
      end
   end

   logic        out_v_ff;
   logic [63:0] out_data_ff;
   logic [1:0]  out_user_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (dl.found) begin
            out_data_ff <= {oy, ox};
            out_user_ff <= {satx | saty, 1'b1};
         end else begin
            out_data_ff <= '0;
            out_user_ff <= '0;
         end
      end
   end

   // advance all stage valid bits together
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff   <= 1'b0;
         b_v_ff   <= 1'b0;
         c_v_ff   <= 1'b0;
         d_v_ff   <= 1'b0;
         e_v_ff   <= 1'b0;
         out_v_ff <= 1'b0;
         for (int k = 0; k <= NDIV; k++) begin
            vd_ff[k] <= 1'b0;
         end
      end else if (en) begin
         a_v_ff   <= vc_ff[CORDIC_STEPS];
         b_v_ff   <= a_v_ff;
         c_v_ff   <= b_v_ff;
         d_v_ff   <= c_v_ff;
         e_v_ff   <= d_v_ff;
         vd_ff[0] <= e_v_ff;
         for (int k = 1; k <= NDIV; k++) begin
            vd_ff[k] <= vd_ff[k-1];
         end
         out_v_ff <= vd_ff[NDIV];
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

`ifndef SYNTHESIS
   a_no_point_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 64'd0 && !rsp_tuser[1])
      else $error("result without intersection carries nonzero data");

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready disagrees with output stall");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result word present right after reset");

   a_found_needs_det: assert property (@(posedge clock) disable iff (reset)
      d_found_ff && en |=> e_pay_ff.d != '0)
      else $error("intersection accepted with zero determinant");
`endif

endmodule

`default_nettype wire

// ----- rtl/pli_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// pli_cordic_cell: one CORDIC rotation step
// Rotates (x, y) by the fixed angle of its step toward z = 0, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_cordic_cell #(
   parameter int STEP = 0
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic signed [pli_pkg::CW-1:0] src_x,
   input  wire logic signed [pli_pkg::CW-1:0] src_y,
   input  wire logic signed [pli_pkg::CW-1:0] src_z,
   output logic signed [pli_pkg::CW-1:0]      dst_x,
   output logic signed [pli_pkg::CW-1:0]      dst_y,
   output logic signed [pli_pkg::CW-1:0]      dst_z
);
   import pli_pkg::*;

   localparam logic signed [CW-1:0] ANGLE = $signed({{(CW-32){1'b0}}, atan_turn(STEP)});

   logic signed [CW-1:0] x_ff, y_ff, z_ff;
   logic signed [CW-1:0] x_in, y_in, z_in;
   logic signed [CW-1:0] xs, ys;

   always_comb begin
      xs = src_x >>> STEP;
      ys = src_y >>> STEP;
      if (!src_z[CW-1]) begin
         x_in = src_x - ys;
         y_in = src_y + xs;
         z_in = src_z - ANGLE;
      end else begin
         x_in = src_x + ys;
         y_in = src_y - xs;
         z_in = src_z + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign dst_x = x_ff;
   assign dst_y = y_ff;
   assign dst_z = z_ff;

endmodule

`default_nettype wire

// ----- rtl/pli_div_cell.sv -----
// ----------------------------------------------------------------------------
// pli_div_cell: one restoring divider step
// Resolves one quotient bit by a compare and subtract of the shifted divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_div_cell #(
   parameter int SHIFT = 0
) (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic [pli_pkg::D_W-1:0]      d,
   input  wire logic [pli_pkg::REM_W-1:0]    src_rem,
   input  wire logic [pli_pkg::QUO_W-1:0]    src_quo,
   output logic [pli_pkg::REM_W-1:0]         dst_rem,
   output logic [pli_pkg::QUO_W-1:0]         dst_quo
);
   import pli_pkg::*;

   logic [REM_W-1:0] rem_ff, rem_in, dsh;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic             ge;

   always_comb begin
      dsh    = REM_W'(d) << SHIFT;
      ge     = (src_rem >= dsh);
      rem_in = ge ? (src_rem - dsh) : src_rem;
      quo_in = src_quo;
      quo_in[SHIFT] = ge;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign dst_rem = rem_ff;
   assign dst_quo = quo_ff;

endmodule

`default_nettype wire
